// ===== hw/rtl/crhp_pkg.sv =====
// Shared types and constants for the Content-Range header parser.
// No dependencies; every module of the block imports this package.
package crhp_pkg;

   localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [2:0]  PREFIX_LEN = 3'd6;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // one input word
   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_text;
   } crhp_req_type;

   // one result word
   typedef struct packed {
      logic        ok;
      logic [63:0] first_byte;
      logic [63:0] last_byte;
      logic [63:0] total_length;
   } crhp_rsp_type;

   // parsed value handed from front to back; length not yet signed/saturated
   typedef struct packed {
      logic        parse_ok;
      logic [63:0] first_val;
      logic [63:0] last_val;
      logic [63:0] len_raw;
      logic        len_minus;
      logic        len_sat;
   } crhp_fin_type;

   // expected character of the "bytes " prefix
   function automatic logic [7:0] prefix_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h62; // b
         3'd1:    c = 8'h79; // y
         3'd2:    c = 8'h74; // t
         3'd3:    c = 8'h65; // e
         3'd4:    c = 8'h73; // s
         3'd5:    c = CHAR_SPACE;
         default: c = CHAR_NUL;
      endcase
      return c;
   endfunction

endpackage

// ===== hw/rtl/crhp_front.sv =====
// Front end: character-by-character parse of the Content-Range value.
// Depends on crhp_pkg; pushes one crhp_fin_type word per value.
module crhp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  crhp_pkg::crhp_req_type req_data,
   output logic                  fin_valid,
   input  logic                  fin_ready,
   output crhp_pkg::crhp_fin_type fin_data
);
   import crhp_pkg::*;

   typedef enum logic [3:0] {
      PH_PREFIX, PH_F1_START, PH_F1_WS, PH_F1_SIGN, PH_F2_WS, PH_F2_SIGN,
      PH_SLASH, PH_F3_START, PH_F3_WS, PH_F3_SIGN, PH_TAIL, PH_STOPPED
   } phase_type;

   typedef enum logic [1:0] {NUM_TAKEN, NUM_ENDED, NUM_NONE} num_res_type;

   phase_type   phase_ff, phase_in;
   logic [2:0]  prefix_pos_ff, prefix_pos_in;
   logic [63:0] acc_ff, acc_in;
   logic        minus_ff, minus_in;
   logic        digit_ff, digit_in;
   logic        sat_ff, sat_in;
   logic [63:0] first_ff, first_in;
   logic [63:0] last_ff, last_in;
   logic        failed_ff, failed_in;

   logic        accept;
   logic [7:0]  c;
   logic        is_digit, is_ws, is_sign, in_sign;
   logic [3:0]  dval;
   logic [67:0] acc_x10;
   logic [63:0] fin_val;
   phase_type   ws_ph, sign_ph;

   num_res_type ns_res;
   phase_type   ns_phase;
   logic [63:0] ns_acc;
   logic        ns_sat, ns_digit, ns_minus;

   logic        f3_group;

   assign accept    = req_valid && req_ready;
   assign req_ready = fin_ready;
   assign fin_valid = accept && req_data.end_of_text;

   assign c        = req_data.ch;
   assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   assign is_ws    = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   assign is_sign  = (c == CHAR_PLUS) || (c == CHAR_MINUS);
   assign dval     = 4'(c - CHAR_ZERO);
   assign in_sign  = (phase_ff == PH_F1_SIGN) || (phase_ff == PH_F2_SIGN) ||
                     (phase_ff == PH_F3_SIGN);

   // acc*10 + d, carry-out above bit 63 means saturation
   assign acc_x10 = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + {64'd0, dval};

   assign fin_val = sat_ff ? ALL_ONES : (minus_ff ? (~acc_ff) + 64'd1 : acc_ff);

   always_comb begin
      case (phase_ff)
         PH_F1_START, PH_F1_WS, PH_F1_SIGN: begin
            ws_ph   = PH_F1_WS;
            sign_ph = PH_F1_SIGN;
         end
         PH_F2_WS, PH_F2_SIGN: begin
            ws_ph   = PH_F2_WS;
            sign_ph = PH_F2_SIGN;
         end
         default: begin
            ws_ph   = PH_F3_WS;
            sign_ph = PH_F3_SIGN;
         end
      endcase
   end

   // strtoul-style step of the current number
   always_comb begin
      ns_res   = NUM_NONE;
      ns_phase = phase_ff;
      ns_acc   = acc_ff;
      ns_sat   = sat_ff;
      ns_digit = digit_ff;
      ns_minus = minus_ff;
      if (is_digit) begin
         ns_res   = NUM_TAKEN;
         ns_digit = 1'b1;
         if (!sat_ff) begin
            if (|acc_x10[67:64]) begin
               ns_sat = 1'b1;
            end else begin
               ns_acc = acc_x10[63:0];
            end
         end
      end else if (digit_ff) begin
         ns_res = NUM_ENDED;
      end else if (!in_sign && is_ws) begin
         ns_res   = NUM_TAKEN;
         ns_phase = ws_ph;
      end else if (!in_sign && is_sign) begin
         ns_res   = NUM_TAKEN;
         ns_minus = (c == CHAR_MINUS);
         ns_phase = sign_ph;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      prefix_pos_in = prefix_pos_ff;
      acc_in        = acc_ff;
      minus_in      = minus_ff;
      digit_in      = digit_ff;
      sat_in        = sat_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      failed_in     = failed_ff;

      if (!failed_ff) begin
         case (phase_ff)
            PH_PREFIX: begin
               if (c == prefix_char(prefix_pos_ff)) begin
                  prefix_pos_in = prefix_pos_ff + 3'd1;
                  if (prefix_pos_ff == PREFIX_LEN - 3'd1) begin
                     phase_in = PH_F1_START;
                  end
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_F1_START, PH_F1_WS, PH_F1_SIGN: begin
               if (phase_ff == PH_F1_START && c == CHAR_STAR) begin
                  first_in = 64'd0;
                  last_in  = ALL_ONES;
                  phase_in = PH_SLASH;
               end else if (ns_res == NUM_TAKEN) begin
                  phase_in = ns_phase;
                  acc_in   = ns_acc;
                  sat_in   = ns_sat;
                  digit_in = ns_digit;
                  minus_in = ns_minus;
               end else if (ns_res == NUM_ENDED && c == CHAR_MINUS) begin
                  first_in = fin_val;
                  acc_in   = 64'd0;
                  sat_in   = 1'b0;
                  digit_in = 1'b0;
                  minus_in = 1'b0;
                  phase_in = PH_F2_WS;
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_F2_WS, PH_F2_SIGN: begin
               if (ns_res == NUM_TAKEN) begin
                  phase_in = ns_phase;
                  acc_in   = ns_acc;
                  sat_in   = ns_sat;
                  digit_in = ns_digit;
                  minus_in = ns_minus;
               end else if (ns_res == NUM_ENDED && c == CHAR_SLASH) begin
                  last_in  = fin_val;
                  acc_in   = 64'd0;
                  sat_in   = 1'b0;
                  digit_in = 1'b0;
                  minus_in = 1'b0;
                  phase_in = PH_F3_START;
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_SLASH: begin
               if (c == CHAR_SLASH) begin
                  phase_in = PH_F3_START;
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_F3_START, PH_F3_WS, PH_F3_SIGN: begin
               if (phase_ff == PH_F3_START && c == CHAR_STAR) begin
                  acc_in   = ALL_ONES;
                  phase_in = PH_TAIL;
               end else if (ns_res == NUM_TAKEN) begin
                  phase_in = ns_phase;
                  acc_in   = ns_acc;
                  sat_in   = ns_sat;
                  digit_in = ns_digit;
                  minus_in = ns_minus;
               end else if (ns_res == NUM_ENDED) begin
                  acc_in   = fin_val;
                  sat_in   = 1'b0;
                  digit_in = 1'b0;
                  minus_in = 1'b0;
                  if (c == CHAR_NUL) begin
                     phase_in = PH_STOPPED;
                  end else begin
                     failed_in = 1'b1;
                  end
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_TAIL: begin
               if (c == CHAR_NUL) begin
                  phase_in = PH_STOPPED;
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_STOPPED: begin
            end
            default: failed_in = 1'b1;
         endcase
      end
   end

   // value summary taken from the post-step state
   assign f3_group = (phase_in == PH_F3_START) || (phase_in == PH_F3_WS) ||
                     (phase_in == PH_F3_SIGN);

   always_comb begin
      fin_data.parse_ok  = !failed_in && ((f3_group && digit_in) ||
                           phase_in == PH_TAIL || phase_in == PH_STOPPED);
      fin_data.first_val = first_in;
      fin_data.last_val  = last_in;
      fin_data.len_raw   = acc_in;
      fin_data.len_minus = f3_group && minus_in;
      fin_data.len_sat   = f3_group && sat_in;
   end

   always_ff @(posedge clock) begin
      if (reset || fin_valid) begin
         phase_ff      <= PH_PREFIX;
         prefix_pos_ff <= 3'd0;
         acc_ff        <= 64'd0;
         minus_ff      <= 1'b0;
         digit_ff      <= 1'b0;
         sat_ff        <= 1'b0;
         first_ff      <= 64'd0;
         last_ff       <= ALL_ONES;
         failed_ff     <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         prefix_pos_ff <= prefix_pos_in;
         acc_ff        <= acc_in;
         minus_ff      <= minus_in;
         digit_ff      <= digit_in;
         sat_ff        <= sat_in;
         first_ff      <= first_in;
         last_ff       <= last_in;
         failed_ff     <= failed_in;
      end
   end

   a_eot_restarts: assert property (@(posedge clock) disable iff (reset)
      fin_valid |=> phase_ff == PH_PREFIX && !failed_ff && prefix_pos_ff == 3'd0)
      else $error("front did not restart after end of text");

   a_prefix_done: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_PREFIX |-> prefix_pos_ff == PREFIX_LEN)
      else $error("left prefix phase before full prefix");

   a_tail_no_digit: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_TAIL || phase_ff == PH_STOPPED) |-> !digit_ff)
      else $error("closed length still holds a digit");

   a_sat_needs_digit: assert property (@(posedge clock) disable iff (reset)
      sat_ff |-> digit_ff)
      else $error("saturation without digits");

endmodule

// ===== hw/rtl/crhp_queue.sv =====
// Short FIFO of parsed values between front and back.
// Depends on crhp_pkg for the word type.
module crhp_queue #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  crhp_pkg::crhp_fin_type push_data,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output crhp_pkg::crhp_fin_type pop_data
);
   import crhp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   crhp_fin_type     slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count overflow");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("queue count did not rise on push");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> wr_ptr_ff == rd_ptr_ff)
      else $error("empty queue with pointer gap");

endmodule

// ===== hw/rtl/crhp_back.sv =====
// Back end: finishes the length and runs the range checks.
// Depends on crhp_pkg; two register stages, the second is the result register.
module crhp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fin_valid,
   output logic                  fin_ready,
   input  crhp_pkg::crhp_fin_type fin_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output crhp_pkg::crhp_rsp_type rsp_data
);
   import crhp_pkg::*;

   logic        a_valid_ff, a_valid_in;
   logic        a_ok_ff;
   logic        a_order_ff;
   logic [63:0] a_first_ff, a_last_ff, a_len_ff, a_span_ff;
   logic [63:0] len_val, span_val;

   logic         rsp_valid_ff, rsp_valid_in;
   crhp_rsp_type rsp_ff;
   logic         check_ok;

   logic out_load, a_adv;

   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign a_adv     = !a_valid_ff || out_load;
   assign fin_ready = a_adv;

   assign len_val  = fin_data.len_sat ? ALL_ONES :
                     (fin_data.len_minus ? (~fin_data.len_raw) + 64'd1 : fin_data.len_raw);
   assign span_val = fin_data.last_val - fin_data.first_val + 64'd1;

   assign a_valid_in   = a_adv ? fin_valid : a_valid_ff;
   assign rsp_valid_in = out_load ? a_valid_ff : rsp_valid_ff;
   assign check_ok     = a_ok_ff && a_order_ff && (a_span_ff <= a_len_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv) begin
         a_ok_ff    <= fin_data.parse_ok;
         a_order_ff <= fin_data.last_val >= fin_data.first_val;
         a_first_ff <= fin_data.first_val;
         a_last_ff  <= fin_data.last_val;
         a_len_ff   <= len_val;
         a_span_ff  <= span_val;
      end
      if (out_load) begin
         rsp_ff.ok           <= check_ok;
         rsp_ff.first_byte   <= check_ok ? a_first_ff : 64'd0;
         rsp_ff.last_byte    <= check_ok ? a_last_ff : 64'd0;
         rsp_ff.total_length <= check_ok ? a_len_ff : 64'd0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.ok |-> rsp_data.first_byte == 64'd0 &&
      rsp_data.last_byte == 64'd0 && rsp_data.total_length == 64'd0)
      else $error("rejected value carries data");

   a_ok_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.ok |-> rsp_data.last_byte >= rsp_data.first_byte)
      else $error("accepted value out of order");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !out_load |=> a_valid_ff)
      else $error("stalled stage dropped its word");

endmodule

// ===== hw/rtl/content_range_header_parser_core.sv =====
// Top level of the Content-Range header parser.
// Depends on crhp_pkg, crhp_front, crhp_queue and crhp_back.
//
// Takes a Content-Range value ("bytes first-last/length", star forms allowed)
// one character per word and, on the word marked end_of_text, returns one
// result word: ok plus first_byte, last_byte and total_length. Numbers follow
// base-10 strtoul rules on 64 bits (leading whitespace, optional sign, minus
// negates, overflow saturates to all ones); a NUL right after the length ends
// the text and the rest up to the end mark is ignored. A rejected value gives
// ok low and all three values zero. Throughput is one character per cycle
// while the queue has room; the front's step (a compare plus multiply-by-ten
// accumulate) is combinational. The parsed value then waits in a
// QUEUE_DEPTH-word queue; the back end finishes the length and runs the range
// checks in two register stages, the last of which is the result register
// that drives rsp_data. A stalled result side stops only the back end; the
// front keeps taking characters until the queue fills.
module content_range_header_parser_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  crhp_pkg::crhp_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output crhp_pkg::crhp_rsp_type rsp_data
);
   import crhp_pkg::*;

   // front to queue
   logic         push_valid, push_ready;
   crhp_fin_type push_data;
   // queue to back
   logic         pop_valid, pop_ready;
   crhp_fin_type pop_data;

   crhp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .fin_valid (push_valid),
      .fin_ready (push_ready),
      .fin_data  (push_data)
   );

   crhp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   crhp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .fin_valid (pop_valid),
      .fin_ready (pop_ready),
      .fin_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for content_range_header_parser_core.
// Needs crhp_pkg and the parser RTL; streams Content-Range values one character per
// word; checks every result word against a cycle-free parse model or typed answer.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import crhp_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 400;   // long result-side stall in the pressure phase
   localparam int PHASE_CHARS  = 170;   // characters per idling phase of the random part
   localparam int TAIL_CYCLES  = 16;    // idle stretch after the last drain before the end
   localparam int PRINT_LIMIT  = 40;

   localparam logic [47:0] PREFIX_TEXT = "bytes ";
   localparam string       WS_CHARS    = "\040\011\012\013\014\015";

   // parse phases of the model
   typedef enum logic [3:0] {
      ST_PREFIX, ST_F1_START, ST_F1_WS, ST_F1_SIGN, ST_F2_WS, ST_F2_SIGN,
      ST_SLASH, ST_F3_START, ST_F3_WS, ST_F3_SIGN, ST_TAIL, ST_STOPPED
   } parse_state_type;

   // what one character did to a number in progress
   typedef enum logic [1:0] { NUM_TAKEN, NUM_ENDED, NUM_NONE } num_step_type;

   typedef struct {
      bit           typed;
      crhp_rsp_type want;
   } row_want_type;

   typedef struct {
      string        text;   // '@' stands for a NUL character
      bit           typed;
      crhp_rsp_type want;
   } dir_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   crhp_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   crhp_rsp_type rsp_data;

   crhp_rsp_type pending_ranges [$];   // expected result words, oldest first
   row_want_type row_want_q [$];       // one entry per value in flight at the input
   dir_row_type  dir_table [$];

   int error_count   = 0;
   int cycle_count   = 0;
   int chars_sent    = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_requests = 0;
   int holds_done    = 0;

   // model state
   parse_state_type st;
   logic [2:0]   pfx_pos;
   logic [63:0]  acc;
   logic         minus_seen, digit_seen, sat, failed;
   logic [63:0]  first_val, last_val;

   content_range_header_parser_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------- model

   function automatic void clear_parse();
      st         = ST_PREFIX;
      pfx_pos    = 3'd0;
      acc        = '0;
      minus_seen = 1'b0;
      digit_seen = 1'b0;
      sat        = 1'b0;
      first_val  = '0;
      last_val   = ALL_ONES;
      failed     = 1'b0;
   endfunction

   function automatic bit is_space(logic [7:0] c);
      return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   // strtoul accumulate; sticks at saturation once the next digit would overflow
   function automatic void push_digit(logic [3:0] d);
      if (!sat) begin
         if (acc > (ALL_ONES - {60'd0, d}) / 64'd10)
            sat = 1'b1;
         else
            acc = acc * 64'd10 + {60'd0, d};
      end
   endfunction

   function automatic logic [63:0] close_number();
      logic [63:0] v;
      if (sat)
         v = ALL_ONES;
      else if (minus_seen)
         v = 64'd0 - acc;
      else
         v = acc;
      acc        = '0;
      minus_seen = 1'b0;
      digit_seen = 1'b0;
      sat        = 1'b0;
      return v;
   endfunction

   // one character of a number field; whitespace and sign only before digits
   function automatic num_step_type take_numeric(logic [7:0] c, parse_state_type ws_st,
                                                 parse_state_type sign_st);
      logic is_dig;
      is_dig = (c >= CHAR_ZERO && c <= CHAR_NINE);
      if (digit_seen) begin
         if (is_dig) begin
            push_digit(c[3:0]);
            return NUM_TAKEN;
         end
         return NUM_ENDED;
      end
      if (is_dig) begin
         digit_seen = 1'b1;
         push_digit(c[3:0]);
         return NUM_TAKEN;
      end
      if (st != sign_st && is_space(c)) begin
         st = ws_st;
         return NUM_TAKEN;
      end
      if (st != sign_st && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
         minus_seen = (c == CHAR_MINUS);
         st = sign_st;
         return NUM_TAKEN;
      end
      return NUM_NONE;
   endfunction

   // advances the model by one accepted word; returns 1 with a result on the end word
   function automatic bit parse_char(input crhp_req_type w, output crhp_rsp_type r);
      logic [7:0]   c;
      num_step_type n;
      logic         good;
      logic [63:0]  len;
      c = w.ch;
      r = '0;
      if (!failed) begin
         case (st)
            ST_PREFIX: begin
               if (pfx_pos < PREFIX_LEN && c == PREFIX_TEXT[8*(5-pfx_pos) +: 8]) begin
                  pfx_pos = pfx_pos + 3'd1;
                  if (pfx_pos == PREFIX_LEN)
                     st = ST_F1_START;
               end else
                  failed = 1'b1;
            end
            ST_F1_START, ST_F1_WS, ST_F1_SIGN: begin
               if (st == ST_F1_START && c == CHAR_STAR) begin
                  first_val = '0;
                  last_val  = ALL_ONES;
                  st        = ST_SLASH;
               end else begin
                  n = take_numeric(c, ST_F1_WS, ST_F1_SIGN);
                  if (n == NUM_ENDED && c == CHAR_MINUS) begin
                     first_val = close_number();
                     st        = ST_F2_WS;
                  end else if (n != NUM_TAKEN)
                     failed = 1'b1;
               end
            end
            ST_F2_WS, ST_F2_SIGN: begin
               n = take_numeric(c, ST_F2_WS, ST_F2_SIGN);
               if (n == NUM_ENDED && c == CHAR_SLASH) begin
                  last_val = close_number();
                  st       = ST_F3_START;
               end else if (n != NUM_TAKEN)
                  failed = 1'b1;
            end
            ST_SLASH: begin
               if (c == CHAR_SLASH)
                  st = ST_F3_START;
               else
                  failed = 1'b1;
            end
            ST_F3_START, ST_F3_WS, ST_F3_SIGN: begin
               if (st == ST_F3_START && c == CHAR_STAR) begin
                  acc = ALL_ONES;
                  st  = ST_TAIL;
               end else begin
                  n = take_numeric(c, ST_F3_WS, ST_F3_SIGN);
                  if (n == NUM_ENDED) begin
                     acc = close_number();
                     if (c == CHAR_NUL)
                        st = ST_STOPPED;
                     else
                        failed = 1'b1;
                  end else if (n != NUM_TAKEN)
                     failed = 1'b1;
               end
            end
            ST_TAIL: begin
               if (c == CHAR_NUL)
                  st = ST_STOPPED;
               else
                  failed = 1'b1;
            end
            ST_STOPPED: ;
            default: failed = 1'b1;
         endcase
      end

      if (!w.end_of_text)
         return 1'b0;

      good = !failed;
      len  = '0;
      if (good) begin
         if ((st == ST_F3_START || st == ST_F3_WS || st == ST_F3_SIGN) && digit_seen)
            len = close_number();
         else if (st == ST_TAIL || st == ST_STOPPED)
            len = acc;
         else
            good = 1'b0;
      end
      if (good && last_val < first_val)
         good = 1'b0;
      // span with 64-bit wraparound must fit the length
      if (good && (last_val - first_val + 64'd1) > len)
         good = 1'b0;
      if (good)
         r = '{1'b1, first_val, last_val, len};
      clear_parse();
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (error_count < PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
      error_count++;
   endtask

   // Result side checked before the input side; latency keeps the two apart anyway.
   always @(posedge clock) begin : scoreboard
      crhp_rsp_type want, calc;
      row_want_type rw;
      if (reset)
         clear_parse();
      else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_ranges.size() == 0)
               report_mismatch("unexpected result, ok", {63'd0, rsp_data.ok}, 64'd0);
            else begin
               want = pending_ranges.pop_front();
               if (rsp_data.ok !== want.ok)
                  report_mismatch("ok", {63'd0, rsp_data.ok}, {63'd0, want.ok});
               if (rsp_data.first_byte !== want.first_byte)
                  report_mismatch("first_byte", rsp_data.first_byte, want.first_byte);
               if (rsp_data.last_byte !== want.last_byte)
                  report_mismatch("last_byte", rsp_data.last_byte, want.last_byte);
               if (rsp_data.total_length !== want.total_length)
                  report_mismatch("total_length", rsp_data.total_length, want.total_length);
            end
         end
         if (req_valid && req_ready) begin
            if (parse_char(req_data, calc)) begin
               // hand-typed rows take their own answer, the rest the model's
               if (row_want_q.size() != 0) begin
                  rw = row_want_q.pop_front();
                  pending_ranges.push_back(rw.typed ? rw.want : calc);
               end else
                  pending_ranges.push_back(calc);
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic add_row(string text, bit typed, logic ok, logic [63:0] f,
                          logic [63:0] l, logic [63:0] n);
      dir_row_type row;
      row.text  = text;
      row.typed = typed;
      row.want  = '{ok, f, l, n};
      dir_table.push_back(row);
   endtask

   // number text with the strtoul extras: leading whitespace, sign, zeros, overflow
   function automatic string num_text(logic [63:0] v);
      string s;
      int    k;
      s = "";
      if ($urandom_range(99) < 15) begin
         k = $urandom_range(5);
         s = {s, WS_CHARS.substr(k, k)};
         if ($urandom_range(1) == 1) begin
            k = $urandom_range(5);
            s = {s, WS_CHARS.substr(k, k)};
         end
      end
      k = $urandom_range(99);
      if (k < 8)
         s = {s, "+"};
      else if (k < 12)
         s = {s, "-"};
      if ($urandom_range(99) < 8)
         s = {s, "00"};
      k = $urandom_range(99);
      if (k < 4)
         s = {s, "99999999999999999999"};
      else if (k < 7)
         s = {s, "18446744073709551616"};
      else
         s = {s, $sformatf("%0d", v)};
      return s;
   endfunction

   // mostly well-formed values with random content; some damaged, a few pure noise
   task automatic make_value(output logic [7:0] chars [$]);
      logic [63:0] f, l, n;
      string       s;
      int          pick, pos, i;
      chars = {};
      pick  = $urandom_range(99);
      if (pick < 5) begin
         repeat ($urandom_range(1, 8)) chars.push_back(8'($urandom_range(255)));
         return;
      end
      f = ($urandom_range(9) == 0) ? {$urandom, $urandom} : 64'($urandom_range(1000));
      l = f + 64'($urandom_range(600));
      n = l - f + 64'd1 + 64'($urandom_range(3));
      if ($urandom_range(7) == 0)
         n = n - 64'd2;   // now and then short of the span by one or two
      s = "bytes ";
      if ($urandom_range(6) == 0)
         s = {s, "*"};
      else
         s = {s, num_text(f), "-", num_text(l)};
      s = {s, "/"};
      if ($urandom_range(6) == 0)
         s = {s, "*"};
      else
         s = {s, num_text(n)};
      for (i = 0; i < s.len(); i++)
         chars.push_back(s[i]);
      if ($urandom_range(4) == 0) begin
         chars.push_back(CHAR_NUL);
         repeat ($urandom_range(3)) chars.push_back(8'($urandom_range(255)));
      end
      if (pick < 20) begin
         pos = $urandom_range(chars.size() - 1);
         case ($urandom_range(2))
            0: chars[pos] = 8'($urandom_range(255));
            1: chars.insert(pos, 8'($urandom_range(255)));
            default: begin
               while (chars.size() > pos + 1)
                  void'(chars.pop_back());
            end
         endcase
      end
   endtask

   // one value, one word per character, end mark on the last; valid held
   // high across back-to-back words, dropped only for an idle stretch
   task automatic send_value(input logic [7:0] chars [$], input bit typed,
                             input crhp_rsp_type want);
      crhp_req_type w;
      row_want_type rw;
      int           i;
      rw.typed = typed;
      rw.want  = want;
      row_want_q.push_back(rw);
      for (i = 0; i < chars.size(); i++) begin
         w.ch          = chars[i];
         w.end_of_text = (i == chars.size() - 1);
         if ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while ($urandom_range(99) < send_idle_pct)
               @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data  <= w;
         @(posedge clock);
         while (!req_ready)
            @(posedge clock);
         chars_sent++;
      end
   endtask

   // sender stands back until every expected result word has come out
   task automatic drain();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (pending_ranges.size() != 0 || row_want_q.size() != 0);
   endtask

   // result side: random stalls, or one long hold-off when asked for
   initial begin : receiver
      int held;
      while (reset)
         @(posedge clock);
      forever begin
         @(posedge clock);
         if (holds_done != hold_requests) begin
            rsp_ready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++)
               @(posedge clock);
            holds_done++;
         end else
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin : main
      logic [7:0]   chars [$];
      crhp_rsp_type none;
      int           i, k, ph, budget;
      none = '0;

      // Directed rows; typed answers only where obvious at a glance.
      add_row("bytes 0-0/1", 1, 1'b1, 64'd0, 64'd0, 64'd1);
      add_row("bytes */*", 1, 1'b1, 64'd0, ALL_ONES, ALL_ONES);
      add_row({"bytes 18446744073709551615-18446744073709551615",
               "/18446744073709551615"}, 1, 1'b1, ALL_ONES, ALL_ONES, ALL_ONES);
      add_row("bytes 0-18446744073709551616/*", 0, 1'b0, '0, '0, '0);
      add_row("bytes 99999999999999999999999-1/5", 1, 1'b0, '0, '0, '0);
      add_row("bytes -1-5/10", 0, 1'b0, '0, '0, '0);
      add_row("bytes \011\012\013\014\015 5- +7/ 0010", 0, 1'b0, '0, '0, '0);
      add_row("bytes 5-3/10", 1, 1'b0, '0, '0, '0);
      add_row("bytes 0-9/9", 1, 1'b0, '0, '0, '0);
      add_row("bytes 0-9/10", 1, 1'b1, 64'd0, 64'd9, 64'd10);
      add_row("bytes 10-20/*", 0, 1'b0, '0, '0, '0);
      add_row("bytes 1-2/3@garbage\377\001", 0, 1'b0, '0, '0, '0);
      add_row("bytes */5@", 0, 1'b0, '0, '0, '0);
      add_row("bytes 1-2/*@x", 0, 1'b0, '0, '0, '0);
      add_row("bytes 1-2/*x", 1, 1'b0, '0, '0, '0);
      add_row("bytes 1-2/3x", 1, 1'b0, '0, '0, '0);
      add_row("bytes", 1, 1'b0, '0, '0, '0);
      add_row("byte@s 1-2/3", 1, 1'b0, '0, '0, '0);
      add_row("Bytes 1-2/3", 1, 1'b0, '0, '0, '0);
      add_row("bytes 1-2", 1, 1'b0, '0, '0, '0);
      add_row("bytes  *-1/2", 1, 1'b0, '0, '0, '0);
      add_row("bytes 1-2/", 1, 1'b0, '0, '0, '0);
      add_row("bytes + 1-2/3", 1, 1'b0, '0, '0, '0);
      add_row("bytes 1-2/-3", 0, 1'b0, '0, '0, '0);
      add_row("bytes 1-@2/3", 1, 1'b0, '0, '0, '0);
      add_row("bytes 1*-2/3", 1, 1'b0, '0, '0, '0);
      add_row("bytes 5-/9", 1, 1'b0, '0, '0, '0);
      add_row("x", 1, 1'b0, '0, '0, '0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part, no idling on either side
      foreach (dir_table[r]) begin
         chars = {};
         for (i = 0; i < dir_table[r].text.len(); i++)
            chars.push_back(dir_table[r].text[i] == "@" ? CHAR_NUL : dir_table[r].text[i]);
         send_value(chars, dir_table[r].typed, dir_table[r].want);
      end
      drain();

      // random part over the idling phases: none, sender, receiver, both
      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
         endcase
         budget = chars_sent + PHASE_CHARS;
         while (chars_sent < budget) begin
            make_value(chars);
            send_value(chars, 0, none);
         end
         drain();
      end

      // pressure: long hold on the result side while values keep coming,
      // so the queue fills and the input stalls
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_requests++;
      for (k = 0; k < 14; k++) begin
         make_value(chars);
         send_value(chars, 0, none);
      end
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/crhp_pkg.sv
hw/rtl/crhp_front.sv
hw/rtl/crhp_queue.sv
hw/rtl/crhp_back.sv
hw/rtl/content_range_header_parser_core.sv
bench/tb_top.sv
